// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
package tcw_pkg;

	localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET     = 8'h03;
	localparam logic [15:0] CELL_RESET    = {ATTR_RESET, CHAR_SPACE};

	localparam int OUT_INDEX_W  = 11;
	localparam int OUT_ROW_W    = 5;
	localparam int OUT_COLUMN_W = 7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef enum logic [1:0] {
		OP_PRINT     = 2'd0,
		OP_NEWLINE   = 2'd1,
		OP_BACKSPACE = 2'd2
	} tcw_op_kind_t;

	typedef struct packed {
		tcw_op_kind_t kind;
		logic [7:0]   code;
	} tcw_op_t;

	typedef struct packed {
		logic q_full;
		logic clearing;
	} tcw_front_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR    = 4'b0001,
		ST_IDLE     = 4'b0010,
		ST_SCAN_RD  = 4'b0100,
		ST_SCAN_CMP = 4'b1000
	} tcw_state_t;

endpackage

// ===== rtl/core/tcw_front.sv =====
// Input side: accepts character bytes and classifies them into operations.
module tcw_front
	import tcw_pkg::*;
(
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     character,
	input  tcw_front_ctl_t ctl,
	output logic           push,
	output tcw_op_t        push_op
);

	always_comb begin
		in_ready = !ctl.q_full && !ctl.clearing;
		push = in_valid && in_ready;
		push_op.code = character;
		priority if (character == CHAR_NEWLINE) begin
			push_op.kind = OP_NEWLINE;
		end else if (character == CHAR_BACKSPACE) begin
			push_op.kind = OP_BACKSPACE;
		end else begin
			push_op.kind = OP_PRINT;
		end
	end

endmodule

// ===== rtl/core/tcw_queue.sv =====
// Short operation queue between the input side and the screen engine.
module tcw_queue
	import tcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  tcw_op_t push_op,
	input  logic    pop,
	output logic    head_valid,
	output tcw_op_t head_op,
	output logic    full
);

	tcw_op_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];
	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcw_back.sv =====
// Screen engine: cursor, cell store, backspace scan and the result register.
module tcw_back
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              attribute,
	input  logic                    op_valid,
	input  tcw_op_t                 op,
	output logic                    pop,
	output logic                    clearing,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    cell_written,
	output logic [OUT_INDEX_W-1:0]  cell_index,
	output logic [15:0]             cell_value,
	output logic [OUT_ROW_W-1:0]    cursor_row,
	output logic [OUT_COLUMN_W-1:0] cursor_column
);

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ROW_W = $clog2(SCREEN_ROWS);
	localparam int COL_W = $clog2(SCREEN_COLUMNS);
	localparam int IDX_W = $clog2(CELLS);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
	localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(CELLS - 1);

	logic [15:0]      mem [CELLS];
	logic [15:0]      rdata_q;

	tcw_state_t       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             out_valid_q;
	logic             written_q;
	logic [IDX_W-1:0] index_q;
	logic [15:0]      value_q;

	logic [15:0]      blank;
	logic [IDX_W-1:0] cur_idx;
	logic [ROW_W-1:0] row_inc;
	logic             take;
	logic             scan_more;
	logic             we;
	logic             re;
	logic [IDX_W-1:0] waddr;
	logic [15:0]      wdata;
	logic             res_done;
	logic             res_written;
	logic [IDX_W-1:0] res_index;
	logic [15:0]      res_value;

	logic [IDX_W+OUT_INDEX_W-1:0]  index_ext;
	logic [ROW_W+OUT_ROW_W-1:0]    row_ext;
	logic [COL_W+OUT_COLUMN_W-1:0] col_ext;

	always_comb begin
		blank       = {attribute, CHAR_SPACE};
		cur_idx     = IDX_W'(IDX_W'(row_q) * IDX_W'(SCREEN_COLUMNS)) + IDX_W'(col_q);
		row_inc     = (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
		take        = (state_q == ST_IDLE) && op_valid && (!out_valid_q || out_ready);
		scan_more   = (col_q != '0) && (rdata_q == blank);
		we          = 1'b0;
		re          = 1'b0;
		waddr       = cur_idx;
		wdata       = blank;
		res_done    = 1'b0;
		res_written = 1'b1;
		res_index   = cur_idx;
		res_value   = blank;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = CELL_RESET;
			end
			ST_IDLE: begin
				if (take) begin
					unique case (op.kind)
						OP_PRINT: begin
							we        = 1'b1;
							wdata     = {attribute, op.code};
							res_done  = 1'b1;
							res_value = {attribute, op.code};
						end
						OP_BACKSPACE: begin
							if (col_q != '0) begin
								we        = 1'b1;
								waddr     = cur_idx - 1'b1;
								res_done  = 1'b1;
								res_index = cur_idx - 1'b1;
							end else if (row_q == '0) begin
								we       = 1'b1;
								res_done = 1'b1;
							end
						end
						default: begin
							we          = 1'b0;
							res_done    = 1'b1;
							res_written = 1'b0;
							res_index   = '0;
							res_value   = '0;
						end
					endcase
				end
			end
			ST_SCAN_RD: re = 1'b1;
			ST_SCAN_CMP: begin
				we       = !scan_more;
				res_done = !scan_more;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[cur_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (res_done) begin
			written_q <= res_written;
			index_q   <= res_index;
			value_q   <= res_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CELL_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						unique case (op.kind)
							OP_NEWLINE: begin
								col_q <= '0;
								row_q <= row_inc;
							end
							OP_PRINT: begin
								if (col_q == COL_LAST) begin
									col_q <= '0;
									row_q <= row_inc;
								end else begin
									col_q <= col_q + 1'b1;
								end
							end
							OP_BACKSPACE: begin
								if (col_q != '0) begin
									col_q <= col_q - 1'b1;
								end else if (row_q != '0) begin
									row_q   <= row_q - 1'b1;
									col_q   <= COL_LAST;
									state_q <= ST_SCAN_RD;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_CMP;
				ST_SCAN_CMP: begin
					if (scan_more) begin
						col_q   <= col_q - 1'b1;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		index_ext = (IDX_W + OUT_INDEX_W)'(index_q);
		row_ext   = (ROW_W + OUT_ROW_W)'(row_q);
		col_ext   = (COL_W + OUT_COLUMN_W)'(col_q);
	end

	assign pop           = take;
	assign clearing      = (state_q == ST_CLEAR);
	assign out_valid     = out_valid_q;
	assign cell_written  = written_q;
	assign cell_index    = index_ext[OUT_INDEX_W-1:0];
	assign cell_value    = value_q;
	assign cursor_row    = row_ext[OUT_ROW_W-1:0];
	assign cursor_column = col_ext[OUT_COLUMN_W-1:0];

endmodule

// ===== rtl/core/text_console_char_writer_core.sv =====
// Top level of the text console character writer.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   text_attribute
//   in       in         in_valid/in_ready     character
//   out      out        out_valid/out_ready   cell_written, cell_index, cell_value,
//                                             cursor_row, cursor_column
//
// After reset the cell store is cleared to blanks, one cell per cycle, so no
// character is taken until every cell has been cleared.
// A character reaches the screen engine through a registered two-entry queue;
// newline, printable bytes and backspaces that need no scan then finish in the idle state.
// A backspace at column 0 of a row other than the first scans the previous
// row from its last column backwards, reading each cell in ST_SCAN_RD and
// comparing it in ST_SCAN_CMP, since the read of the cell store is registered.
// A stalled output holds its result while the queue keeps taking input until it is full.
module text_console_char_writer_core
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [7:0]              text_attribute,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              character,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    cell_written,
	output logic [OUT_INDEX_W-1:0]  cell_index,
	output logic [15:0]             cell_value,
	output logic [OUT_ROW_W-1:0]    cursor_row,
	output logic [OUT_COLUMN_W-1:0] cursor_column
);

	logic           [7:0] attr_q;
	logic           push;
	tcw_op_t        push_op;
	logic           pop;
	logic           head_valid;
	tcw_op_t        head_op;
	logic           q_full;
	logic           clearing;
	tcw_front_ctl_t front_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= text_attribute;
		end
	end

	assign front_ctl.q_full   = q_full;
	assign front_ctl.clearing = clearing;

	tcw_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.character (character),
		.ctl       (front_ctl),
		.push      (push),
		.push_op   (push_op)
	);

	tcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.full       (q_full)
	);

	tcw_back #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.attribute     (attr_q),
		.op_valid      (head_valid),
		.op            (head_op),
		.pop           (pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.cell_written  (cell_written),
		.cell_index    (cell_index),
		.cell_value    (cell_value),
		.cursor_row    (cursor_row),
		.cursor_column (cursor_column)
	);

endmodule
